[sv/chkv_pkg.sv]
// ----------------------------------------------------------------------------
// chkv_pkg
// shared types, constants and mixer helpers for the chained hash store
// ----------------------------------------------------------------------------
package chkv_pkg;

	localparam int unsigned BUCKETS_DEF = 256;
	localparam int unsigned NODES_DEF   = 256;
	localparam logic [31:0] MIX_MULT    = 32'h045d9f3b;
	localparam int unsigned MIX_SHIFT   = 16;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MIX1,
		ST_MIX2,
		ST_HEAD,
		ST_HEAD_WAIT,
		ST_NODE,
		ST_NODE_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mix1;
		logic mix2;
		logic head_rd;
		logic head_chk;
		logic node_rd;
		logic node_chk;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic head_empty;
		logic hit;
		logic chain_end;
	} sts_t;

	function automatic logic [31:0] xs(input logic [31:0] x);
		xs = (x >> MIX_SHIFT) ^ x;
	endfunction

endpackage

[sv/chained_hash_key_value_store.sv]
// ----------------------------------------------------------------------------
// chained_hash_key_value_store
// chained hash key-value store with a fixed node pool
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries cmd, key, new_value; one result word
// per input word on out_valid/out_ready carrying found, stored_value, pool_full.
// an item goes through these steps: accept, two mixer
// multiply rounds, bucket head read and check, one node read and check per
// chain step, and a final step that loads the result register.
// the final step waits while the result register is still held by a stalled
// receiver, so a stalled receiver holds the input off.
// reset empties all buckets and the node pool at once; node memories need no
// clearing since they are only reached through written links.
module chained_hash_key_value_store #(
	parameter int unsigned BUCKETS = chkv_pkg::BUCKETS_DEF,
	parameter int unsigned NODES   = chkv_pkg::NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [31:0] key,
	input  logic signed [31:0] new_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic signed [31:0] stored_value,
	output logic               pool_full
);
	import chkv_pkg::*;

	ctl_t ctl;
	sts_t sts;

	chkv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_busy(out_valid && !out_ready), .sts(sts), .ctl(ctl)
	);

	chkv_dp #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .cmd(cmd), .key(key),
		.new_value(new_value), .out_ready(out_ready), .out_valid(out_valid),
		.found(found), .stored_value(stored_value), .pool_full(pool_full)
	);

endmodule

[sv/chkv_ctrl.sv]
// ----------------------------------------------------------------------------
// chkv_ctrl
// sequencer: hash rounds, bucket head read, chain walk, result hand-off
// ----------------------------------------------------------------------------
module chkv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_busy,
	input  chkv_pkg::sts_t sts,
	output chkv_pkg::ctl_t ctl
);
	import chkv_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_MIX1;
				end
			end
			ST_MIX1: begin
				ctl.mix1 = 1'b1;
				state_d  = ST_MIX2;
			end
			ST_MIX2: begin
				ctl.mix2 = 1'b1;
				state_d  = ST_HEAD;
			end
			ST_HEAD: begin
				ctl.head_rd = 1'b1;
				state_d     = ST_HEAD_WAIT;
			end
			ST_HEAD_WAIT: begin
				ctl.head_chk = 1'b1;
				state_d      = sts.head_empty ? ST_DONE : ST_NODE;
			end
			ST_NODE: begin
				ctl.node_rd = 1'b1;
				state_d     = ST_NODE_WAIT;
			end
			ST_NODE_WAIT: begin
				ctl.node_chk = 1'b1;
				state_d      = (sts.hit || sts.chain_end) ? ST_DONE : ST_NODE;
			end
			ST_DONE: begin
				if (!out_busy) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[sv/chkv_dp.sv]
// ----------------------------------------------------------------------------
// chkv_dp
// datapath: mixer, bucket head table, node pool memories, result register
// ----------------------------------------------------------------------------
module chkv_dp #(
	parameter int unsigned BUCKETS = chkv_pkg::BUCKETS_DEF,
	parameter int unsigned NODES   = chkv_pkg::NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  chkv_pkg::ctl_t     ctl,
	output chkv_pkg::sts_t     sts,
	input  logic               cmd,
	input  logic signed [31:0] key,
	input  logic signed [31:0] new_value,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               found,
	output logic signed [31:0] stored_value,
	output logic               pool_full
);
	import chkv_pkg::*;

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int PW = $clog2(NODES + 1);

	logic [PW-1:0] head_mem [BUCKETS];
	logic [BUCKETS-1:0] head_vld_q;
	logic [31:0]   nkey_mem [NODES];
	logic [31:0]   nval_mem [NODES];
	logic [PW-1:0] nlink_mem [NODES];

	logic          cmd_q;
	logic [31:0]   key_q, val_q, x_q;
	logic [BW-1:0] bkt_q;
	logic [PW-1:0] head_rd_q, cur_q, last_q, used_q, steps_q;
	logic          head_hv_q;
	logic [31:0]   rkey_q, rval_q;
	logic [PW-1:0] rlink_q;
	logic          hit_q, full_q;
	logic [31:0]   stored_q;
	logic [PW-1:0] hitn_q;
	logic          out_valid_q;

	logic [31:0] mixed;
	logic [PW-1:0] head_val;
	logic [NW-1:0] cur_idx;

	function automatic logic [31:0] bmod_next(input logic [31:0] m);
		logic [31:0] y;
		y = xs(m);
		bmod_next = (BUCKETS & (BUCKETS - 1)) == 0 ? (y & 32'(BUCKETS - 1))
			: y % 32'(BUCKETS);
	endfunction

	assign mixed   = xs(x_q) * MIX_MULT;
	assign head_val = head_hv_q ? head_rd_q : '0;
	assign cur_idx  = NW'(cur_q - PW'(1));

	assign sts.head_empty = (head_val == '0);
	assign sts.hit        = (rkey_q == key_q);
	assign sts.chain_end  = (rlink_q == '0) || (rlink_q > PW'(NODES))
		|| (steps_q >= PW'(NODES));

	always_ff @(posedge clk) begin
		head_rd_q <= head_mem[bkt_q];
		if (ctl.node_rd) begin
			rkey_q  <= nkey_mem[cur_idx];
			rval_q  <= nval_mem[cur_idx];
			rlink_q <= nlink_mem[cur_idx];
		end
		if (ctl.load) begin
			cmd_q <= cmd;
			key_q <= key;
			val_q <= new_value;
			x_q   <= key;
		end
		if (ctl.mix1 || ctl.load == 1'b0 && ctl.mix2) x_q <= mixed;
		if (ctl.head_rd) bkt_q <= bkt_q;
		if (ctl.head_chk) begin
			cur_q   <= head_val;
			last_q  <= '0;
			steps_q <= '0;
			hit_q   <= 1'b0;
		end
		if (ctl.node_chk) begin
			if (sts.hit) begin
				hit_q  <= 1'b1;
				hitn_q <= cur_q;
				stored_q <= rval_q;
			end else begin
				last_q  <= cur_q;
				cur_q   <= rlink_q;
				steps_q <= steps_q + PW'(1);
			end
		end
		if (ctl.finish) begin
			if (cmd_q == CMD_INSERT && hit_q)
				nval_mem[NW'(hitn_q - PW'(1))] <= val_q;
			else if (cmd_q == CMD_INSERT && used_q < PW'(NODES)) begin
				nkey_mem[NW'(used_q)]  <= key_q;
				nval_mem[NW'(used_q)]  <= val_q;
				nlink_mem[NW'(used_q)] <= '0;
				if (last_q == '0) head_mem[bkt_q] <= used_q + PW'(1);
				else nlink_mem[NW'(last_q - PW'(1))] <= used_q + PW'(1);
			end
			found        <= hit_q;
			stored_value <= hit_q ? stored_q : '0;
			pool_full    <= (cmd_q == CMD_INSERT) && !hit_q && (used_q >= PW'(NODES));
		end
		if (ctl.mix2) bkt_q <= BW'(bmod_next(mixed));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q  <= '0;
			head_hv_q   <= 1'b0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.head_rd) head_hv_q <= head_vld_q[bkt_q];
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
				if (cmd_q == CMD_INSERT && !hit_q && used_q < PW'(NODES)) begin
					used_q <= used_q + PW'(1);
					if (last_q == '0) head_vld_q[bkt_q] <= 1'b1;
				end
			end else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/chkv_checker.sv]
// ----------------------------------------------------------------------------
// chkv_checker
// port-level checks for the chained hash store
// ----------------------------------------------------------------------------
module chkv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [31:0] stored_value,
	input logic        pool_full
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stored_value))
		else $error("result word dropped while stalled");
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && pool_full))
		else $error("found and pool_full together");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> stored_value == 32'd0)
		else $error("nonzero value on miss");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken during work");
endmodule

bind chained_hash_key_value_store chkv_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .found(found),
	.stored_value(stored_value), .pool_full(pool_full)
);

[tb/tb_chained_hash_key_value_store.sv]
// ----------------------------------------------------------------------------
// tb_chained_hash_key_value_store
// self-checking testbench for the chained hash key-value store
// ----------------------------------------------------------------------------
// a directed table covers the extreme keys and values, updates and misses.
// random lookups and inserts follow; most of them reuse keys already stored,
// and the node pool fills up so that dropped inserts are exercised too. typed
// rows are checked against the table, others against a behavioral model of the
// buckets, chains, pool. sender and receiver idle at random in three phases.
module tb_chained_hash_key_value_store;
	timeunit 1ns;
	timeprecision 1ps;

	import chkv_pkg::*;

	localparam int unsigned N_BUCKETS = 256;
	localparam int unsigned N_NODES   = 256;
	localparam int PHASE_ITEMS        = 570;
	localparam int STALL_LIMIT        = 20000;

	typedef struct {
		logic        found;
		logic [31:0] value;
		logic        full;
	} answer_t;

	typedef struct {
		logic        op;
		logic [31:0] k;
		logic [31:0] v;
		bit          typed;
		answer_t     ans;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               cmd = CMD_LOOKUP;
	logic signed [31:0] key = '0;
	logic signed [31:0] new_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               found;
	logic signed [31:0] stored_value;
	logic               pool_full;

	chained_hash_key_value_store dut (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .key, .new_value,
		.out_valid, .out_ready, .found, .stored_value, .pool_full
	);

	// model of the store
	logic [8:0]  head_of [N_BUCKETS];
	logic [31:0] pair_key [N_NODES];
	logic [31:0] pair_val [N_NODES];
	logic [8:0]  next_of [N_NODES];
	int unsigned used_nodes;

	answer_t     pending_q [$];
	logic [31:0] known_keys [$];
	int          errors = 0;
	int          snd_idle = 0;
	int          rcv_idle = 0;
	int          quiet = 0;

	row_t dir_rows [15] = '{
		'{CMD_LOOKUP, 32'h0, 32'h0, 1, '{1'b0, 32'h0, 1'b0}},
		'{CMD_INSERT, 32'h80000000, 32'h7fffffff, 1, '{1'b0, 32'h0, 1'b0}},
		'{CMD_LOOKUP, 32'h80000000, 32'h0, 1, '{1'b1, 32'h7fffffff, 1'b0}},
		'{CMD_INSERT, 32'h7fffffff, 32'h80000000, 1, '{1'b0, 32'h0, 1'b0}},
		'{CMD_INSERT, 32'h80000000, 32'h0, 1, '{1'b1, 32'h7fffffff, 1'b0}},
		'{CMD_LOOKUP, 32'h7fffffff, 32'hffffffff, 1, '{1'b1, 32'h80000000, 1'b0}},
		'{CMD_INSERT, 32'hffffffff, 32'hffffffff, 1, '{1'b0, 32'h0, 1'b0}},
		'{CMD_INSERT, 32'h0, 32'h1, 0, '{1'b0, 32'h0, 1'b0}},
		'{CMD_LOOKUP, 32'hffffffff, 32'h0, 0, '{1'b0, 32'h0, 1'b0}},
		'{CMD_LOOKUP, 32'h1, 32'h0, 0, '{1'b0, 32'h0, 1'b0}},
		'{CMD_INSERT, 32'haaaaaaaa, 32'h55555555, 0, '{1'b0, 32'h0, 1'b0}},
		'{CMD_INSERT, 32'h55555555, 32'haaaaaaaa, 0, '{1'b0, 32'h0, 1'b0}},
		'{CMD_LOOKUP, 32'haaaaaaaa, 32'h0, 0, '{1'b0, 32'h0, 1'b0}},
		'{CMD_INSERT, 32'h0, 32'h12345678, 0, '{1'b0, 32'h0, 1'b0}},
		'{CMD_LOOKUP, 32'h0, 32'h0, 0, '{1'b0, 32'h0, 1'b0}}
	};

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] mix_step(input logic [31:0] x);
		logic [31:0] s;
		s = (x >> 16) ^ x;
		return s * MIX_MULT;
	endfunction

	function automatic int unsigned bucket_index(input logic [31:0] k);
		logic [31:0] x;
		x = mix_step(mix_step(k));
		x = (x >> 16) ^ x;
		return x % N_BUCKETS;
	endfunction

	function automatic answer_t store_access(input logic op, input logic [31:0] k,
			input logic [31:0] v);
		answer_t     a;
		int unsigned b;
		logic [8:0]  cur;
		logic [8:0]  last;
		int unsigned steps;
		a = '{1'b0, 32'h0, 1'b0};
		b = bucket_index(k);
		cur = head_of[b];
		last = '0;
		steps = 0;
		while (cur != 0 && steps < N_NODES) begin
			if (pair_key[cur - 1] == k) begin
				a.found = 1'b1;
				a.value = pair_val[cur - 1];
				if (op == CMD_INSERT)
					pair_val[cur - 1] = v;
				break;
			end
			last = cur;
			cur = next_of[cur - 1];
			steps++;
		end
		if (op == CMD_INSERT && !a.found) begin
			if (used_nodes >= N_NODES) begin
				a.full = 1'b1;
			end else begin
				pair_key[used_nodes] = k;
				pair_val[used_nodes] = v;
				next_of[used_nodes] = '0;
				if (last == 0)
					head_of[b] = 9'(used_nodes + 1);
				else
					next_of[last - 1] = 9'(used_nodes + 1);
				used_nodes++;
				known_keys.push_back(k);
			end
		end
		return a;
	endfunction

	task automatic send_word(input logic op, input logic [31:0] k, input logic [31:0] v,
			input bit typed, input answer_t ans);
		int gap;
		answer_t a;
		gap = 0;
		while ($urandom_range(99) < snd_idle)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		key <= k;
		new_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		a = store_access(op, k, v);
		pending_q.push_back(typed ? ans : a);
	endtask

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 60 && known_keys.size() > 0)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		else if (r < 80)
			return 32'($signed($urandom_range(40)) - 20);
		return $urandom;
	endfunction

	task automatic run_phase(input int s_idle, input int r_idle);
		logic [31:0] k;
		snd_idle = s_idle;
		rcv_idle = r_idle;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			k = pick_key();
			send_word($urandom_range(1) ? CMD_INSERT : CMD_LOOKUP, k, $urandom, 0,
				'{1'b0, 32'h0, 1'b0});
		end
		// let everything drain before moving on
		in_valid <= 1'b0;
		wait (pending_q.size() == 0);
		@(posedge clk);
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= rcv_idle);

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: found %0b value %h full %0b",
						found, stored_value, pool_full);
			end else begin
				e = pending_q.pop_front();
				if (found !== e.found || stored_value !== e.value || pool_full !== e.full) begin
					errors++;
					if (errors <= 10)
						$display("result mismatch: exp %0b/%h/%0b got %0b/%h/%0b",
							e.found, e.value, e.full, found, stored_value, pool_full);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("chained_hash_key_value_store: mismatch");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < N_BUCKETS; i++)
			head_of[i] = '0;
		used_nodes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle = 38;
		rcv_idle = 88;
		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].k, dir_rows[i].v, dir_rows[i].typed,
				dir_rows[i].ans);
		in_valid <= 1'b0;
		wait (pending_q.size() == 0);
		@(posedge clk);
		run_phase(38, 88);
		run_phase(88, 38);
		run_phase(0, 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("chained_hash_key_value_store: match");
		else
			$display("chained_hash_key_value_store: mismatch");
		$finish;
	end

endmodule
